// ----- hw/rtl/vmhs_pkg.sv -----
// vmhs_pkg: shared types, codes and constants of the heap/stack manager
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package vmhs_pkg;

  localparam int MEM_CELLS_DEF    = 4096;
  localparam int MARGIN_BYTES_DEF = 64;

  localparam int DATA_W     = 32;
  localparam int CELLS_W    = 13;
  localparam int HBASE_W    = 14;
  localparam int SSTART_W   = 15;
  localparam int MBYTES_W   = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 112;

  localparam logic [CELLS_W-1:0]  PUSH_SAT       = 13'd4096;
  localparam logic [DATA_W-1:0]   STACK_PTR_RST  = 32'd16384;
  localparam logic [HBASE_W-1:0]  HEAP_BASE_RST  = 14'd0;
  localparam logic [SSTART_W-1:0] STACK_START_RST = 15'd16384;
  localparam logic [MBYTES_W-1:0] MEM_BYTES_RST  = 15'd16384;
  localparam logic [DATA_W-1:0]   CELL_BYTES     = 32'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_BYTES   = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_POP     = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_PUSH    = 3'd4,
    CMD_CHECK   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_HEAP_LOW = 2'd1,
    STS_INVALID  = 2'd2,
    STS_STACKERR = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [MBYTES_W-1:0] memory_bytes;
    logic [SSTART_W-1:0] stack_start;
    logic [HBASE_W-1:0]  heap_base;
  } vmhs_cfg_t;

  // packed lsb first: status, addr_out, heap_top, stack_ptr, push_total
  typedef struct packed {
    logic [CELLS_W-1:0]  push_total;
    logic [DATA_W-1:0]   stack_ptr;
    logic [DATA_W-1:0]   heap_top;
    logic [DATA_W-1:0]   addr_out;
    logic [STATUS_W-1:0] status;
  } vmhs_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vm_heap_stack_manager_core.sv -----
// vm_heap_stack_manager_core: heap/stack manager of a script machine's data memory
// top level: configuration registers, output register, exec and cell memory
// uses vmhs_pkg, vmhs_exec, vmhs_cell_mem
//
// usage
//   in channel: one command per transfer; in_tuser carries the command code,
//   in_tdata the operands. out channel: one result per command, carrying the status
//   and the heap pointer, stack pointer and push count after it. the user writes
//   cfg port (heap_base, stack_start, memory_bytes) only while idle; not enforced.
// sequence
//   a command passes through the transfer, in which the cell memory read
//   for heap pop starts, and the execute step, which uses the read data
//   and writes back pointers and cells. the result is loaded into the output
//   register as the execute step commits; no new command is taken until it does.
// stall
//   the output register lets the next command in while a result waits; if
//   out_tready stays low the execute step holds until the register drains.
// reset
//   heap pointer 0, stack pointer 16384, push count 0, config to its defaults;
//   the cell memory is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module vm_heap_stack_manager_core #(
  parameter int MEM_CELLS    = vmhs_pkg::MEM_CELLS_DEF,
  parameter int MARGIN_BYTES = vmhs_pkg::MARGIN_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // addr [31:0], cell_count [44:32], value [76:45], zero [79:77]
  input  wire logic [vmhs_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd [2:0]
  input  wire logic [vmhs_pkg::CMD_W-1:0]        in_tuser,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // status [1:0], addr_out [33:2], heap_top [65:34], stack_ptr [97:66],
  // push_total [110:98], zero [111]
  output      logic [vmhs_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [vmhs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vmhs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vmhs_pkg::*;

  localparam int CELL_AW = $clog2(MEM_CELLS);

  vmhs_cfg_t    cfg_r;
  logic         out_valid_r;
  vmhs_result_t out_data_r;

  logic               res_valid;
  logic               res_ready;
  vmhs_result_t       res;
  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [CELL_AW-1:0] mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heap_base    <= HEAP_BASE_RST;
      cfg_r.stack_start  <= STACK_START_RST;
      cfg_r.memory_bytes <= MEM_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAP_BASE:   cfg_r.heap_base    <= cfg_wdata[HBASE_W-1:0];
        CFG_STACK_START: cfg_r.stack_start  <= cfg_wdata[SSTART_W-1:0];
        CFG_MEM_BYTES:   cfg_r.memory_bytes <= cfg_wdata[MBYTES_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  vmhs_exec #(
    .MEM_CELLS    (MEM_CELLS),
    .MARGIN_BYTES (MARGIN_BYTES),
    .CELL_AW      (CELL_AW)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_addr   (in_tdata[31:0]),
    .in_cells  (in_tdata[44:32]),
    .in_value  (in_tdata[76:45]),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  vmhs_cell_mem #(
    .MEM_CELLS (MEM_CELLS),
    .CELL_AW   (CELL_AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register takes a result when empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && res_valid)
    else $error("command accepted while another is executing");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_tvalid)
    else $error("finished result not loaded into output register");

  a_push_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[110:98] <= PUSH_SAT)
    else $error("push count above saturation");

  a_no_mem_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> res_valid && res_ready)
    else $error("cell memory written outside a committing command");

endmodule

`default_nettype wire

// ----- hw/rtl/vmhs_cell_mem.sv -----
// vmhs_cell_mem: single-port-write, single-read data cell memory
// registered read; uses vmhs_pkg
`timescale 1ns / 1ps
`default_nettype none

module vmhs_cell_mem #(
  parameter int MEM_CELLS = vmhs_pkg::MEM_CELLS_DEF,
  parameter int CELL_AW   = $clog2(MEM_CELLS)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [CELL_AW-1:0]          waddr,
  input  wire logic [vmhs_pkg::DATA_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [CELL_AW-1:0]          raddr,
  output      logic [vmhs_pkg::DATA_W-1:0] rdata
);
  import vmhs_pkg::*;

  logic [DATA_W-1:0] mem_r [MEM_CELLS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/vmhs_exec.sv -----
// vmhs_exec: command sequencer, heap/stack pointers and push counter
// reads and writes the cell memory; uses vmhs_pkg
`timescale 1ns / 1ps
`default_nettype none

module vmhs_exec #(
  parameter int MEM_CELLS    = vmhs_pkg::MEM_CELLS_DEF,
  parameter int MARGIN_BYTES = vmhs_pkg::MARGIN_BYTES_DEF,
  parameter int CELL_AW      = $clog2(MEM_CELLS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [vmhs_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [vmhs_pkg::DATA_W-1:0]  in_addr,
  input  wire logic [vmhs_pkg::CELLS_W-1:0] in_cells,
  input  wire logic [vmhs_pkg::DATA_W-1:0]  in_value,
  input  wire vmhs_pkg::vmhs_cfg_t          cfg,
  output      logic                         res_valid,
  input  wire logic                         res_ready,
  output      vmhs_pkg::vmhs_result_t       res,
  output      logic                         mem_we,
  output      logic [CELL_AW-1:0]           mem_waddr,
  output      logic [vmhs_pkg::DATA_W-1:0]  mem_wdata,
  output      logic                         mem_re,
  output      logic [CELL_AW-1:0]           mem_raddr,
  input  wire logic [vmhs_pkg::DATA_W-1:0]  mem_rdata
);
  import vmhs_pkg::*;

  localparam logic [DATA_W-1:0] MARGIN = DATA_W'(MARGIN_BYTES);

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]   cmd_r;
  logic [DATA_W-1:0]  addr_r;
  logic [CELLS_W-1:0] cells_r;
  logic [DATA_W-1:0]  value_r;

  logic [DATA_W-1:0]  hp_r, hp_nxt;
  logic [DATA_W-1:0]  sp_r, sp_nxt;
  logic [CELLS_W-1:0] cnt_r, cnt_nxt;

  logic               accept;
  logic               commit;
  logic [DATA_W-1:0]  in_addr_m4;

  assign accept     = in_valid && in_ready;
  assign commit     = res_valid && res_ready;
  assign in_addr_m4 = in_addr - CELL_BYTES;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_EXEC: res_valid = 1'b1;
      default: in_ready  = 1'b0;
    endcase
  end

  // the size word at addr - 4 is read whenever a command is taken; only pop uses it
  assign mem_re    = accept;
  assign mem_raddr = in_addr_m4[CELL_AW+1:2];

  // command datapath
  always_comb begin
    logic [DATA_W-1:0] hbase;
    logic [DATA_W-1:0] mbytes;
    logic [DATA_W-1:0] real_bytes;
    logic [DATA_W-1:0] room;
    logic [DATA_W-1:0] sp_m4;
    logic [DATA_W-1:0] hp_p4;
    logic [DATA_W-1:0] pop_a;
    logic [DATA_W-1:0] pop_end;
    logic              in_gap;
    hbase      = {{(DATA_W-HBASE_W){1'b0}}, cfg.heap_base};
    mbytes     = {{(DATA_W-MBYTES_W){1'b0}}, cfg.memory_bytes};
    real_bytes = {{(DATA_W-CELLS_W-2){1'b0}}, cells_r, 2'b00};
    room       = sp_r - hp_r - real_bytes;
    sp_m4      = sp_r - CELL_BYTES;
    hp_p4      = hp_r + CELL_BYTES;
    pop_a      = addr_r - CELL_BYTES;
    pop_end    = hp_r - {mem_rdata[DATA_W-3:0], 2'b00} - CELL_BYTES;
    in_gap     = !($signed(addr_r) < $signed(hp_r)) && ($signed(addr_r) < $signed(sp_r));

    hp_nxt       = hp_r;
    sp_nxt       = sp_r;
    cnt_nxt      = cnt_r;
    res.status   = STS_OK;
    res.addr_out = '0;
    mem_we       = 1'b0;
    mem_waddr    = hp_r[CELL_AW+1:2];
    mem_wdata    = {{(DATA_W-CELLS_W){1'b0}}, cells_r};

    case (cmd_r)
      CMD_INIT: begin
        hp_nxt  = hbase;
        sp_nxt  = {{(DATA_W-SSTART_W){1'b0}}, cfg.stack_start};
        cnt_nxt = '0;
      end
      CMD_ALLOC: begin
        if ($signed(room) < $signed(MARGIN)) begin
          res.status = STS_HEAP_LOW;
        end else begin
          mem_we       = commit;
          res.addr_out = hp_p4;
          hp_nxt       = hp_p4 + real_bytes;
        end
      end
      CMD_POP: begin
        if (($signed(pop_a) < $signed(hbase)) || !($signed(pop_a) < $signed(sp_r))) begin
          res.status = STS_INVALID;
        end else if (pop_end != pop_a) begin
          res.status = STS_INVALID;
        end else begin
          hp_nxt = pop_a;
        end
      end
      CMD_RELEASE: begin
        if ($signed(addr_r) < $signed(hbase)) begin
          res.status = STS_INVALID;
        end else begin
          hp_nxt = addr_r - CELL_BYTES;
        end
      end
      CMD_PUSH: begin
        if ($signed(sp_m4) < $signed(hp_r + MARGIN)) begin
          res.status = STS_STACKERR;
        end else begin
          sp_nxt    = sp_m4;
          mem_we    = commit;
          mem_waddr = sp_m4[CELL_AW+1:2];
          mem_wdata = value_r;
          if (cnt_r < PUSH_SAT) begin
            cnt_nxt = cnt_r + CELLS_W'(1);
          end
        end
      end
      CMD_CHECK: begin
        if (in_gap || addr_r[DATA_W-1] || (addr_r >= mbytes)) begin
          res.status = STS_INVALID;
        end else begin
          res.addr_out = addr_r;
        end
      end
      default: begin
        res.status = STS_OK;
      end
    endcase

    res.heap_top   = hp_nxt;
    res.stack_ptr  = sp_nxt;
    res.push_total = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hp_r    <= '0;
      sp_r    <= STACK_PTR_RST;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        hp_r  <= hp_nxt;
        sp_r  <= sp_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_addr;
      cells_r <= in_cells;
      value_r <= in_value;
    end
  end

endmodule

`default_nettype wire
